[rtl/fbfl_pkg.sv]
// Shared types and constants of the fixed-block free-list allocator.
package fbfl_pkg;

  localparam int unsigned NUM_BLOCKS_DEF = 256;

  localparam int unsigned IDX_W    = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned HDR_W    = 12;
  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned LINK_W   = 9;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [COUNT_W-1:0]  BLOCK_COUNT_RST  = 9'd256;
  localparam logic [SIZE_W-1:0]   BLOCK_SIZE_RST   = 13'd16;
  localparam logic [HDR_W-1:0]    HEADER_BYTES_RST = 12'd32;
  localparam logic [OFFSET_W-1:0] OFFSET_MAX       = {OFFSET_W{1'b1}};

  // link entry: top bit marks a present link, low bits hold the next index
  localparam logic [LINK_W-1:0] LINK_NULL = '0;

  typedef enum logic [1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_FREE   = 2'd1,
    REQ_REINIT = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_OVERFLOW = 2'd2,
    STS_RANGE    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BLOCK_COUNT  = 2'd0,
    REG_BLOCK_SIZE   = 2'd1,
    REG_HEADER_BYTES = 2'd2
  } reg_idx_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

[rtl/fixed_block_free_list_allocator_top.sv]
// Fixed-size block allocator: free-list head registers plus link memory.
// An accepted item sets the state register to execute; the execute state loads the
//   result register with the strobe, and the result is taken while the strobe is high.
// No new item is taken while one executes; the accept cycle reads the link memory
//   at the head, the following cycle uses that link, writes the memory, sets the head.
// Reset (rst_n, synchronous, active low): registers to defaults, pool full, head 0;
//   the link memory is not cleared, entry 0 reads as null until it is written.
module fixed_block_free_list_allocator_top
  import fbfl_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          in_req_type,
  input  logic [IDX_W-1:0]    in_block_index,
  // result channel
  output logic                out_strobe,
  output logic [1:0]          out_status,
  output logic [IDX_W-1:0]    out_given_index,
  output logic [OFFSET_W-1:0] out_block_offset,
  output logic [COUNT_W-1:0]  out_free_count,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // Indices never reach 256, so the link memory stops there.
  localparam int unsigned LINK_DEPTH = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
  localparam int unsigned AW         = $clog2(LINK_DEPTH);
  // Pool size at reset: the default block count capped at the memory depth.
  localparam logic [COUNT_W-1:0] N_RST =
    (BLOCK_COUNT_RST > COUNT_W'(LINK_DEPTH)) ? COUNT_W'(LINK_DEPTH) : BLOCK_COUNT_RST;

  // ---------------------------------------------------------------- config
  logic [COUNT_W-1:0] block_count_r;
  logic [SIZE_W-1:0]  block_size_r;
  logic [HDR_W-1:0]   header_bytes_r;
  logic               cfg_wr;
  logic [1:0]         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_count_r  <= BLOCK_COUNT_RST;
      block_size_r   <= BLOCK_SIZE_RST;
      header_bytes_r <= HEADER_BYTES_RST;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_BLOCK_COUNT:  block_count_r  <= pwdata[COUNT_W-1:0];
        REG_BLOCK_SIZE:   block_size_r   <= pwdata[SIZE_W-1:0];
        REG_HEADER_BYTES: header_bytes_r <= pwdata[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_BLOCK_COUNT:  prdata = PDATA_W'(block_count_r);
      REG_BLOCK_SIZE:   prdata = PDATA_W'(block_size_r);
      REG_HEADER_BYTES: prdata = PDATA_W'(header_bytes_r);
      default:          prdata = '0;
    endcase
  end

  // Usable pool size: block_count capped at the link memory depth.
  logic [COUNT_W-1:0] n_eff;
  assign n_eff = (block_count_r > COUNT_W'(LINK_DEPTH)) ? COUNT_W'(LINK_DEPTH)
                                                        : block_count_r;

  // ---------------------------------------------------------------- control
  state_t state_r, state_nxt;
  logic   accept;
  logic   mem_we;

  assign accept = start && !busy;

  always_comb begin
    case (state_r)
      ST_IDLE: state_nxt = accept ? ST_EXEC : ST_IDLE;
      ST_EXEC: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Item captured at accept; payload, so no reset.
  logic [1:0]       req_r;
  logic [IDX_W-1:0] idx_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req_type;
      idx_r <= in_block_index;
    end
  end

  // ---------------------------------------------------------------- list state
  logic [IDX_W-1:0]   head_index_r, head_index_nxt;
  logic               head_valid_r, head_valid_nxt;
  logic [COUNT_W-1:0] free_blocks_r, free_blocks_nxt;
  // Entry 0 is null after reset or reinitialise until a free writes it.
  logic               link0_null_r, link0_null_nxt;

  logic [AW-1:0]      mem_waddr;
  logic [LINK_W-1:0]  mem_wdata;
  logic [LINK_W-1:0]  mem_rdata;
  logic [LINK_W-1:0]  head_link;
  logic [COUNT_W-1:0] next_blk;
  logic [COUNT_W-1:0] free_dec;

  // Read at the head during the accept cycle; data lands for the execute cycle.
  fbfl_ram #(
    .WIDTH (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head_index_r[AW-1:0]),
    .rdata (mem_rdata)
  );

  assign head_link = (head_index_r == '0 && link0_null_r) ? LINK_NULL : mem_rdata;
  assign next_blk  = {1'b0, head_index_r} + COUNT_W'(1);
  assign free_dec  = free_blocks_r - COUNT_W'(1);

  // result fields computed in the execute cycle
  logic [1:0]       res_status;
  logic [IDX_W-1:0] res_index;
  logic             res_has_offset;

  always_comb begin
    head_index_nxt  = head_index_r;
    head_valid_nxt  = head_valid_r;
    free_blocks_nxt = free_blocks_r;
    link0_null_nxt  = link0_null_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = LINK_NULL;
    res_status      = STS_OK;
    res_index       = '0;
    res_has_offset  = 1'b0;

    if (state_r == ST_EXEC) begin
      case (req_r)
        REQ_ALLOC: begin
          if (!head_valid_r || free_blocks_r == '0) begin
            res_status = STS_EMPTY;
          end else begin
            free_blocks_nxt = free_dec;
            res_index       = head_index_r;
            res_has_offset  = 1'b1;
            if (head_link[LINK_W-1]) begin
              head_index_nxt = head_link[IDX_W-1:0];
            end else if (free_dec != '0) begin
              // lazy bump into a block never handed out
              if (next_blk >= n_eff) begin
                head_valid_nxt = 1'b0;
              end else begin
                head_index_nxt = next_blk[IDX_W-1:0];
                mem_we         = 1'b1;
                mem_waddr      = next_blk[AW-1:0];
                mem_wdata      = LINK_NULL;
              end
            end else begin
              head_valid_nxt = 1'b0;
            end
          end
        end
        REQ_FREE: begin
          if ({1'b0, idx_r} >= n_eff) begin
            res_status = STS_RANGE;
          end else if (free_blocks_r >= n_eff) begin
            res_status = STS_OVERFLOW;
          end else begin
            mem_we          = 1'b1;
            mem_waddr       = idx_r[AW-1:0];
            mem_wdata       = head_valid_r ? {1'b1, head_index_r} : LINK_NULL;
            if (idx_r == '0) begin
              link0_null_nxt = 1'b0;
            end
            head_index_nxt  = idx_r;
            head_valid_nxt  = 1'b1;
            free_blocks_nxt = free_blocks_r + COUNT_W'(1);
            res_index       = idx_r;
            res_has_offset  = 1'b1;
          end
        end
        REQ_REINIT: begin
          head_index_nxt  = '0;
          head_valid_nxt  = (n_eff != '0);
          free_blocks_nxt = n_eff;
          link0_null_nxt  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_index_r  <= '0;
      head_valid_r  <= (N_RST != '0);
      free_blocks_r <= N_RST;
      link0_null_r  <= 1'b1;
    end else begin
      head_index_r  <= head_index_nxt;
      head_valid_r  <= head_valid_nxt;
      free_blocks_r <= free_blocks_nxt;
      link0_null_r  <= link0_null_nxt;
    end
  end

  // ---------------------------------------------------------------- offset
  // header + index * size, saturated at the 21-bit ceiling
  logic [OFFSET_W-1:0] prod;
  logic [OFFSET_W:0]   off_sum;
  logic [OFFSET_W-1:0] off_sat;

  assign prod    = OFFSET_W'(res_index) * OFFSET_W'(block_size_r);
  assign off_sum = {1'b0, prod} + (OFFSET_W+1)'(header_bytes_r);
  assign off_sat = off_sum[OFFSET_W] ? OFFSET_MAX : off_sum[OFFSET_W-1:0];

  // ---------------------------------------------------------------- result register
  logic                out_strobe_r;
  logic [1:0]          out_status_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [OFFSET_W-1:0] out_offset_r;
  logic [COUNT_W-1:0]  out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      out_status_r <= res_status;
      out_index_r  <= res_index;
      out_offset_r <= res_has_offset ? off_sat : '0;
      out_count_r  <= free_blocks_nxt;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_given_index  = out_index_r;
  assign out_block_offset = out_offset_r;
  assign out_free_count   = out_count_r;

`ifndef SYNTHESIS
  // every result strobe follows an accepted item
  a_strobe_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 2))
    else $error("result strobe without an accepted item");

  // the execute state is always left in the following cycle
  a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("execute state held for more than one cycle");

  // link memory is written only while an item executes
  a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_EXEC))
    else $error("link memory written outside execution");

  // reported free count matches the state left behind
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_free_count == free_blocks_r))
    else $error("reported free count disagrees with state");
`endif

endmodule

[rtl/fbfl_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module fbfl_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[verif/fixed_block_free_list_allocator_top_tb.sv]
// Self-checking testbench for the fixed-block free-list allocator top level.
`timescale 1ns / 100ps

module fixed_block_free_list_allocator_top_tb
  import fbfl_pkg::*;
();

  // Request code outside the defined set: the block must answer it and change nothing
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 200000;

  typedef struct {
    logic [1:0]       req;
    logic [IDX_W-1:0] idx;
  } request_t;

  typedef struct {
    status_t             status;
    logic [IDX_W-1:0]    index;
    logic [OFFSET_W-1:0] offset;
    logic [COUNT_W-1:0]  count;
  } answer_t;

  // ---------------------------------------------------------------------------
  // Clock and DUT inputs, all known from time zero
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_req_type = '0;
  logic [IDX_W-1:0] in_block_index = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;

  logic busy;
  logic out_strobe;
  logic [1:0] out_status;
  logic [IDX_W-1:0] out_given_index;
  logic [OFFSET_W-1:0] out_block_offset;
  logic [COUNT_W-1:0] out_free_count;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  always #4 clk = ~clk;

  fixed_block_free_list_allocator_top #(
    .NUM_BLOCKS(NUM_BLOCKS_DEF)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_block_index  (in_block_index),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_given_index (out_given_index),
    .out_block_offset(out_block_offset),
    .out_free_count  (out_free_count),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // ---------------------------------------------------------------------------
  // Shared testbench state
  // ---------------------------------------------------------------------------
  request_t request_q[$];           // items waiting for the driver
  answer_t  answer_q[$];            // answers owed by the block, oldest first
  logic [IDX_W-1:0] live_q[$];      // blocks currently handed out, steers frees
  logic item_taken = 1'b0;          // the item on the ports went in at the last edge
  int unsigned sender_idle_pct = 28;
  int unsigned mismatches = 0;
  int unsigned cfg_mismatches = 0;
  int unsigned cycle_count = 0;

  // Shadow copy of the pool: configuration, free-list head and link memory
  logic [COUNT_W-1:0] cfg_count = BLOCK_COUNT_RST;
  logic [SIZE_W-1:0]  cfg_size = BLOCK_SIZE_RST;
  logic [HDR_W-1:0]   cfg_header = HEADER_BYTES_RST;
  logic [IDX_W-1:0]   head_idx = '0;
  logic               head_ok = 1'b1;
  logic [COUNT_W-1:0] free_left = BLOCK_COUNT_RST;
  logic [LINK_W-1:0]  link_mem [NUM_BLOCKS_DEF];

  initial begin
    foreach (link_mem[i]) link_mem[i] = LINK_NULL;
  end

  // Pool size in use: the register capped at the number of blocks the memory holds
  function automatic logic [COUNT_W-1:0] pool_size();
    return (cfg_count > COUNT_W'(NUM_BLOCKS_DEF)) ? COUNT_W'(NUM_BLOCKS_DEF) : cfg_count;
  endfunction

  function automatic logic [OFFSET_W-1:0] byte_offset(input logic [IDX_W-1:0] idx);
    logic [63:0] off;
    off = 64'(cfg_header) + 64'(idx) * 64'(cfg_size);
    return (off > 64'(OFFSET_MAX)) ? OFFSET_MAX : off[OFFSET_W-1:0];
  endfunction

  // Applies one item to the shadow pool and returns the answer it must give
  function automatic answer_t alloc_step(input logic [1:0] req, input logic [IDX_W-1:0] idx);
    answer_t a;
    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] next_idx;
    logic [LINK_W-1:0] lnk;
    int hit;
    a.status = STS_OK;
    a.index = '0;
    a.offset = '0;
    n = pool_size();
    hit = -1;
    case (req)
      REQ_ALLOC: begin
        if (!head_ok || free_left == 0) begin
          a.status = STS_EMPTY;
        end else begin
          lnk = link_mem[head_idx];
          a.index = head_idx;
          a.offset = byte_offset(head_idx);
          free_left = free_left - COUNT_W'(1);
          if (lnk[LINK_W-1]) begin
            head_idx = lnk[IDX_W-1:0];
          end else if (free_left != 0) begin
            // lazy bump: next block in address order, unless it lies past the pool
            next_idx = {1'b0, head_idx} + COUNT_W'(1);
            if (next_idx >= n) begin
              head_ok = 1'b0;
            end else begin
              head_idx = next_idx[IDX_W-1:0];
              link_mem[head_idx] = LINK_NULL;
            end
          end else begin
            head_ok = 1'b0;
          end
          live_q.push_back(a.index);
        end
      end
      REQ_FREE: begin
        if ({1'b0, idx} >= n) begin
          a.status = STS_RANGE;
        end else if (free_left >= n) begin
          a.status = STS_OVERFLOW;
        end else begin
          link_mem[idx] = head_ok ? {1'b1, head_idx} : LINK_NULL;
          head_idx = idx;
          head_ok = 1'b1;
          free_left = free_left + COUNT_W'(1);
          a.index = idx;
          a.offset = byte_offset(idx);
          for (int i = 0; i < live_q.size(); i++) begin
            if (hit < 0 && live_q[i] == idx) hit = i;
          end
          if (hit >= 0) live_q.delete(hit);
        end
      end
      REQ_REINIT: begin
        head_idx = '0;
        head_ok = (n != 0);
        free_left = n;
        link_mem[0] = LINK_NULL;
        live_q.delete();
      end
      default: ;  // unknown code: plain ok answer, pool untouched
    endcase
    a.count = free_left;
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and predictor: sampled at the rising edge. The answer of an earlier
  // item is checked before a newly accepted item is pushed, so the order of the
  // answer queue never depends on scheduling.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    answer_t want;
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("** fixed_block_free_list_allocator_top: FAILED **");
      $finish;
    end else begin
      item_taken = 1'b0;
      if (rst_n) begin
        if (out_strobe === 1'b1) begin
          if (answer_q.size() == 0) begin
            $error("result strobe with no item outstanding");
            mismatches++;
          end else begin
            want = answer_q.pop_front();
            if (out_status !== want.status) begin
              $error("status: expected %0d, got %0d", want.status, out_status);
              mismatches++;
            end
            if (out_given_index !== want.index) begin
              $error("given_index: expected %0d, got %0d", want.index, out_given_index);
              mismatches++;
            end
            if (out_block_offset !== want.offset) begin
              $error("block_offset: expected %0d, got %0d", want.offset, out_block_offset);
              mismatches++;
            end
            if (out_free_count !== want.count) begin
              $error("free_count: expected %0d, got %0d", want.count, out_free_count);
              mismatches++;
            end
          end
        end
        if (start && !busy) begin
          item_taken = 1'b1;
          answer_q.push_back(alloc_step(in_req_type, in_block_index));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: launches items at the falling edge. An item stays on the ports until
  // it is taken; otherwise the sender may idle at random. Every so often it also
  // holds off until all outstanding answers are back.
  // ---------------------------------------------------------------------------
  logic drain_hold = 1'b0;
  int unsigned issued = 0;

  always @(negedge clk) begin : driver
    request_t nxt;
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // item still waiting for the block: hold everything
    end else begin
      if (drain_hold && answer_q.size() == 0) drain_hold = 1'b0;
      if (!drain_hold && request_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
        nxt = request_q.pop_front();
        go = 1'b1;
        issued++;
        if (issued % 89 == 44) drain_hold = 1'b1;
      end
      start <= go;
      if (go) begin
        in_req_type <= nxt.req;
        in_block_index <= nxt.idx;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Register write, then read back; only called while the block is idle
  task automatic cfg_write(input reg_idx_t which, input logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] kept;
    case (which)
      REG_BLOCK_COUNT: kept = value & PDATA_W'({COUNT_W{1'b1}});
      REG_BLOCK_SIZE:  kept = value & PDATA_W'({SIZE_W{1'b1}});
      default:         kept = value & PDATA_W'({HDR_W{1'b1}});
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (which)
      REG_BLOCK_COUNT: cfg_count = kept[COUNT_W-1:0];
      REG_BLOCK_SIZE:  cfg_size = kept[SIZE_W-1:0];
      default:         cfg_header = kept[HDR_W-1:0];
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== kept) begin
      $error("prdata: expected %0d, got %0d", kept, prdata);
      cfg_mismatches++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_pool(input int unsigned cnt, input int unsigned sz, input int unsigned hdr);
    cfg_write(REG_BLOCK_COUNT, cnt);
    cfg_write(REG_BLOCK_SIZE, sz);
    cfg_write(REG_HEADER_BYTES, hdr);
  endtask

  // Wait for every item to go in and every answer to come out
  task automatic settle();
    @(posedge clk);
    #1;
    while (request_q.size() != 0 || start || answer_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (4) @(posedge clk);
  endtask

  // Random item: mostly allocs and frees, frees aimed at blocks in use so the
  // list gets deep; the alloc share swings so the pool runs empty and full.
  function automatic request_t pick_request(input int unsigned k);
    request_t r;
    int unsigned roll;
    int unsigned alloc_pct;
    alloc_pct = ((k / 20) % 2) ? 35 : 65;
    roll = $urandom_range(99, 0);
    r.idx = IDX_W'($urandom_range(255, 0));
    if (roll < alloc_pct) begin
      r.req = REQ_ALLOC;
    end else if (roll < 95) begin
      r.req = REQ_FREE;
      if (live_q.size() != 0 && $urandom_range(9, 0) < 7) begin
        r.idx = live_q[$urandom_range(live_q.size() - 1, 0)];
      end else if ($urandom_range(3, 0) != 0) begin
        r.idx = IDX_W'($urandom_range(pool_size() - 1, 0));
      end
    end else if (roll < 98) begin
      r.req = REQ_REINIT;
    end else begin
      r.req = REQ_UNKNOWN;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed items, then random phases
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned cnt, sz, hdr;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: bump allocs, pushes incl. top index, popping links,
    // unknown code, reinit and a free into a full pool
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_ALLOC, 8'd255});
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_FREE, 8'd1});
    request_q.push_back('{REQ_FREE, 8'd255});
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_UNKNOWN, 8'd255});
    request_q.push_back('{REQ_REINIT, 8'd170});
    request_q.push_back('{REQ_FREE, 8'd0});
    request_q.push_back('{REQ_ALLOC, 8'd85});
    settle();

    // Shrink to one block with the head beyond it: bump past the end, empty pool,
    // out-of-range free, overflow, and a one-block pool cycled through
    set_pool(1, 4096, 4095);
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_FREE, 8'd255});
    request_q.push_back('{REQ_FREE, 8'd0});
    request_q.push_back('{REQ_REINIT, 8'd0});
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_FREE, 8'd0});
    request_q.push_back('{REQ_FREE, 8'd0});
    request_q.push_back('{REQ_ALLOC, 8'd0});
    settle();

    // Smallest block size and header
    set_pool(256, 1, 0);
    request_q.push_back('{REQ_REINIT, 8'd0});
    request_q.push_back('{REQ_ALLOC, 8'd0});
    request_q.push_back('{REQ_FREE, 8'd255});
    settle();

    // Random phases; sender idling 28 %, then 66 %, then none
    for (int p = 0; p < 6; p++) begin
      sender_idle_pct = (p < 2) ? 28 : (p < 4) ? 66 : 0;
      case (p)
        0: begin cnt = 256; sz = 16; hdr = 32; end
        1: begin cnt = 8; sz = 4096; hdr = 4095; end
        2: begin
          cnt = $urandom_range(16, 1);
          sz = $urandom_range(4096, 1);
          hdr = $urandom_range(4095, 0);
        end
        3: begin cnt = 1; sz = 1; hdr = 0; end
        4: begin cnt = 256; sz = 4096; hdr = 4095; end
        default: begin
          cnt = $urandom_range(64, 2);
          sz = $urandom_range(4096, 1);
          hdr = $urandom_range(4095, 0);
        end
      endcase
      set_pool(cnt, sz, hdr);
      if (p % 2 == 1) request_q.push_back('{REQ_REINIT, 8'd0});
      for (int k = 0; k < 105; k++) begin
        // keep the queue short so frees track the blocks actually in use
        while (request_q.size() >= 2) begin
          @(posedge clk);
          #1;
        end
        request_q.push_back(pick_request(k));
      end
      settle();
    end

    if (mismatches == 0 && cfg_mismatches == 0 && answer_q.size() == 0) begin
      $display("** fixed_block_free_list_allocator_top: PASSED **");
    end else begin
      $display("** fixed_block_free_list_allocator_top: FAILED **");
    end
    $finish;
  end

endmodule
